FILE: hdl/trit_pkg.sv
// Package for the TCP reassembly interval tracker.
// Holds fragment types, status and register codes, and serial-number helpers.
// Used by trit_eval and the top level in hdl; trit_ram does not need it.
`timescale 1ns / 1ps
package trit_pkg;

  localparam int MAX_FRAGS_DEF = 16;
  localparam int CNT_W = 7;
  localparam logic [31:0] HALF_SPACE = 32'h7FFF_FFFF;
  localparam logic [15:0] WINDOW_RESET = 16'd8192;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_IGNORED  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [7:0] CFG_WINDOW = 8'd0;
  localparam logic [7:0] CFG_START  = 8'd1;

  localparam logic OP_PUT    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] len;
  } frag_t;

  typedef struct packed {
    logic        hit;
    logic        stop;
    logic [31:0] start;
    logic [15:0] len;
  } eval_t;

  function automatic logic [31:0] serial_min(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    if (a == b) r = a;
    else if (a < b) r = ((b - a) <= HALF_SPACE) ? a : b;
    else r = ((a - b) <= HALF_SPACE) ? b : a;
    return r;
  endfunction

  function automatic logic [31:0] serial_max(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    if (a == b) r = a;
    else if (a < b) r = ((b - a) <= HALF_SPACE) ? b : a;
    else r = ((a - b) <= HALF_SPACE) ? a : b;
    return r;
  endfunction

endpackage

FILE: hdl/trit_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No package dependency.
`timescale 1ns / 1ps
module trit_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/trit_eval.sv
// Join test and merge of the running range against one stored fragment.
// Depends on trit_pkg.
`timescale 1ns / 1ps
module trit_eval import trit_pkg::*; (
  input  logic [31:0] cur_start,
  input  logic [15:0] cur_len,
  input  logic [31:0] seq_end,
  input  frag_t       entry,
  output eval_t       ev
);

  logic [31:0] a_end, b_end, a_end1, b_end1, m_start, m_end, m_len;

  // ranges join unless one ends strictly before the other starts
  always_comb begin
    a_end  = cur_start + {16'b0, cur_len};
    b_end  = entry.start + {16'b0, entry.len};
    a_end1 = a_end + 32'd1;
    b_end1 = b_end + 32'd1;
    m_start = serial_min(cur_start, entry.start);
    m_end   = serial_max(a_end, b_end);
    m_len   = m_end - m_start;
    ev.hit   = !((serial_min(a_end1, entry.start) == a_end1) ||
                 (serial_min(b_end1, cur_start) == b_end1));
    ev.stop  = (serial_max(seq_end, entry.start) == entry.start);
    ev.start = m_start;
    ev.len   = m_len[15:0];
  end

endmodule

FILE: hdl/tcp_reassembly_interval_tracker_unit.sv
// Top level of the TCP reassembly interval tracker.
// Depends on trit_pkg, trit_ram and trit_eval.
`timescale 1ns / 1ps
// Usage:
// Items enter on in_valid/in_ready (opcode, seq_num, byte_count); one result
// leaves per item on out_valid/out_ready. The fragment table lives in one RAM
// with a registered read; entry 0 is mirrored in flops.
// An early-out put (empty, before head, overflow) or empty remove goes
// straight to the final state. A remove that trims the head entry rewrites
// it in place; one that drops it shifts the remaining entries down. A put
// scans the table one entry per cycle up to the stop point; unless the table
// is full, it then shifts the entries behind it one per cycle while compacting
// or opening a slot, drains the last pending write, then writes the new
// entry. Scan and shift together touch each entry once. The RAM's single
// read and write port sets this pace.
// One item is in work at a time; in_ready is high whenever the engine is
// idle, even while a finished result waits in the output register.
// When the receiver stalls, the next item's result holds in the final state
// until the output register frees up.
// Reset empties the table, sets the head to zero and the window to 8192.
// Writing CFG_START empties the table and sets the head to the written value; the window is kept.
module tcp_reassembly_interval_tracker_unit import trit_pkg::*; #(
  parameter int MAX_FRAGS = MAX_FRAGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] seq_num,
  input  logic [15:0] byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] done_len,
  output logic [15:0] in_order_len,
  output logic [31:0] head_sequence,
  output logic [31:0] total_in_order,
  output logic [6:0]  fragment_count,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam cnt_t MAXC = cnt_t'(MAX_FRAGS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_WRNEW  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]  state;
  logic [15:0] window;
  cnt_t        used;
  logic [31:0] head;
  logic [15:0] contig;
  logic [31:0] cum;

  logic [31:0] op_seq;
  logic [15:0] op_len;
  logic [31:0] seq_end;
  logic [1:0]  res_status;
  logic [15:0] res_done;
  logic        do_contig;

  logic        merged;
  cnt_t        idx, merge_at, merge_cnt, stop_at;
  logic [31:0] ns;
  logic [15:0] nl;

  cnt_t        mv_src, mv_rem, mv_off, pend_dst;
  logic        mv_up, mv_new, pend;
  frag_t       new_ent;
  cnt_t        new_at;

  frag_t       sh;
  frag_t       rd_data;
  logic        ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  frag_t       ram_wdata;
  eval_t       ev;

  cnt_t        idx_inc;
  logic [31:0] seq_off;
  logic [32:0] reach;
  logic [15:0] rlen;
  cnt_t        ins_at;
  logic        fin_hit;
  logic [15:0] fin_contig;
  logic [31:0] fin_cum;

  trit_ram #(.WIDTH($bits(frag_t)), .DEPTH(MAX_FRAGS), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  trit_eval u_eval (
    .cur_start (ns),
    .cur_len   (nl),
    .seq_end   (seq_end),
    .entry     (rd_data),
    .ev        (ev)
  );

  assign in_ready = (state == S_IDLE);
  assign idx_inc  = idx + cnt_t'(1);
  assign seq_off  = seq_num - head;
  assign reach    = {1'b0, seq_off} + {17'b0, byte_count};
  assign rlen     = (contig < byte_count) ? contig : byte_count;
  assign ins_at   = ((used == '0) || (serial_min(op_seq, sh.start) == op_seq)) ? '0 : stop_at;

  // contiguous run from the head after a successful put
  assign fin_hit    = do_contig && (used != '0) && (sh.start == head);
  assign fin_contig = fin_hit ? sh.len : contig;
  assign fin_cum    = fin_hit ? (cum + {16'b0, sh.len} - {16'b0, contig}) : cum;

  // RAM address and write selection
  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = new_at[IW-1:0];
    ram_wdata = new_ent;
    case (state)
      S_SCAN: ram_raddr = idx_inc[IW-1:0];
      S_MOVE: begin
        ram_raddr = mv_src[IW-1:0];
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_dst[IW-1:0];
          ram_wdata = rd_data;
        end
      end
      S_WRNEW: ram_we = 1'b1;
      default: ;
    endcase
  end

  // mirror of entry 0
  always_ff @(posedge clk) begin
    if (ram_we && (ram_waddr == '0)) begin
      sh <= ram_wdata;
    end
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      window    <= WINDOW_RESET;
      used      <= '0;
      head      <= '0;
      contig    <= '0;
      cum       <= '0;
      pend      <= 1'b0;
      merged    <= 1'b0;
      do_contig <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_seq  <= seq_num;
            op_len  <= byte_count;
            seq_end <= seq_num + {16'b0, byte_count};
            if (opcode == OP_PUT) begin
              if (byte_count == '0) begin
                res_status <= ST_DONE;
                res_done   <= '0;
                do_contig  <= 1'b0;
                state      <= S_FIN;
              end else if (serial_min(head, seq_num) != head) begin
                res_status <= ST_IGNORED;
                res_done   <= '0;
                do_contig  <= 1'b0;
                state      <= S_FIN;
              end else if (reach > {17'b0, window}) begin
                res_status <= ST_OVERFLOW;
                res_done   <= '0;
                do_contig  <= 1'b0;
                state      <= S_FIN;
              end else begin
                res_status <= ST_DONE;
                res_done   <= byte_count;
                do_contig  <= 1'b1;
                merged     <= 1'b0;
                merge_cnt  <= '0;
                merge_at   <= '0;
                idx        <= '0;
                stop_at    <= '0;
                ns         <= seq_num;
                nl         <= byte_count;
                state      <= (used == '0) ? S_DECIDE : S_SCAN;
              end
            end else begin
              res_status <= ST_DONE;
              do_contig  <= 1'b0;
              if ((rlen != '0) && (used != '0)) begin
                head     <= head + {16'b0, rlen};
                contig   <= contig - rlen;
                res_done <= rlen;
                if (rlen >= sh.len) begin
                  used   <= used - cnt_t'(1);
                  mv_src <= cnt_t'(1);
                  mv_rem <= used - cnt_t'(1);
                  mv_up  <= 1'b0;
                  mv_off <= cnt_t'(1);
                  mv_new <= 1'b0;
                  pend   <= 1'b0;
                  state  <= S_MOVE;
                end else begin
                  new_ent.start <= sh.start + {16'b0, rlen};
                  new_ent.len   <= sh.len - rlen;
                  new_at        <= '0;
                  state         <= S_WRNEW;
                end
              end else begin
                res_done <= '0;
                state    <= S_FIN;
              end
            end
          end
        end
        S_SCAN: begin
          // one stored fragment per cycle; next read already issued
          idx <= idx_inc;
          if (ev.hit) begin
            ns        <= ev.start;
            nl        <= ev.len;
            merged    <= 1'b1;
            merge_cnt <= merge_cnt + cnt_t'(1);
            if (!merged) begin
              merge_at <= idx;
            end
            if (idx_inc == used) begin
              stop_at <= used;
              state   <= S_DECIDE;
            end
          end else if (merged || ev.stop) begin
            stop_at <= idx;
            state   <= S_DECIDE;
          end else if (idx_inc == used) begin
            stop_at <= used;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pend <= 1'b0;
          if (merged) begin
            used          <= used - (merge_cnt - cnt_t'(1));
            mv_src        <= merge_at + merge_cnt;
            mv_rem        <= used - (merge_at + merge_cnt);
            mv_up         <= 1'b0;
            mv_off        <= merge_cnt - cnt_t'(1);
            mv_new        <= 1'b1;
            new_ent.start <= ns;
            new_ent.len   <= nl;
            new_at        <= merge_at;
            state         <= S_MOVE;
          end else if (used >= MAXC) begin
            res_status <= ST_FULL;
            res_done   <= '0;
            do_contig  <= 1'b0;
            state      <= S_FIN;
          end else begin
            used          <= used + cnt_t'(1);
            mv_src        <= used - cnt_t'(1);
            mv_rem        <= used - ins_at;
            mv_up         <= 1'b1;
            mv_off        <= cnt_t'(1);
            mv_new        <= 1'b1;
            new_ent.start <= op_seq;
            new_ent.len   <= op_len;
            new_at        <= ins_at;
            state         <= S_MOVE;
          end
        end
        S_MOVE: begin
          // read one entry, write it back shifted on the next cycle
          if (mv_rem != '0) begin
            pend     <= 1'b1;
            pend_dst <= mv_up ? (mv_src + cnt_t'(1)) : (mv_src - mv_off);
            mv_src   <= mv_up ? (mv_src - cnt_t'(1)) : (mv_src + cnt_t'(1));
            mv_rem   <= mv_rem - cnt_t'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= mv_new ? S_WRNEW : S_FIN;
            end
          end
        end
        S_WRNEW: begin
          state <= S_FIN;
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            done_len       <= res_done;
            in_order_len   <= fin_contig;
            head_sequence  <= head;
            total_in_order <= fin_cum;
            fragment_count <= used;
            contig         <= fin_contig;
            cum            <= fin_cum;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // register writes must arrive only while idle; the block itself does not enforce this
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW: window <= cfg_data[15:0];
          CFG_START: begin
            head   <= cfg_data;
            used   <= '0;
            contig <= '0;
            cum    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // table never grows past its depth
  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= MAXC)
    else $error("fragment count exceeds table depth");

  // RAM is written only while shifting or placing an entry
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_MOVE) || (state == S_WRNEW)))
    else $error("RAM write outside shift or place states");

  // a result leaving the final state shows up on the output
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && (!out_valid || out_ready)) |=> (out_valid && (state == S_IDLE)))
    else $error("finished item did not reach the output");

  // in-order bytes imply a fragment at the head
  a_contig_used: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && (contig != '0)) |-> (used != '0))
    else $error("in-order bytes with an empty table");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the TCP reassembly interval tracker.
// A scoreboard class predicts every result from its own copy of the fragment
// table and checks each one in order; needs trit_pkg and the top level in hdl.
`timescale 1ns / 1ps
module tb;
  import trit_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] done_len;
    logic [15:0] in_order_len;
    logic [31:0] head_sequence;
    logic [31:0] total_in_order;
    logic [6:0]  fragment_count;
  } seg_result_t;

  localparam int NFRAG = MAX_FRAGS_DEF;
  localparam int DRAIN_CYCLES = 2 * NFRAG + 20;
  localparam int STALL_LIMIT = 3000;

  class reassembly_scoreboard;
    logic [31:0] frag_lo[NFRAG];
    logic [15:0] frag_len[NFRAG];
    int          used;
    logic [31:0] head;
    logic [31:0] contig;
    logic [31:0] cumul;
    logic [15:0] win;
    seg_result_t pending_q[$];
    int          errors;

    function void reset_state();
      win = WINDOW_RESET;
      restart(32'd0);
    endfunction

    function void restart(logic [31:0] seq0);
      used = 0;
      head = seq0;
      contig = 0;
      cumul = 0;
    endfunction

    // serial-arithmetic ordering on 32-bit sequence numbers
    function logic [31:0] seq_lo(logic [31:0] a, logic [31:0] b);
      if (a == b) return a;
      if (a < b) return (b - a <= 32'h7FFF_FFFF) ? a : b;
      return (a - b <= 32'h7FFF_FFFF) ? b : a;
    endfunction

    function logic [31:0] seq_hi(logic [31:0] a, logic [31:0] b);
      if (a == b) return a;
      if (a < b) return (b - a <= 32'h7FFF_FFFF) ? b : a;
      return (a - b <= 32'h7FFF_FFFF) ? a : b;
    endfunction

    function bit overlaps(logic [31:0] as, logic [31:0] al, logic [31:0] bs,
                          logic [31:0] bl);
      logic [31:0] ae;
      logic [31:0] be;
      ae = as + al + 1;
      be = bs + bl + 1;
      return !(seq_lo(ae, bs) == ae || seq_lo(be, as) == be);
    endfunction

    function void drop_frag(int k);
      for (int j = k; j + 1 < used; j++) begin
        frag_lo[j] = frag_lo[j+1];
        frag_len[j] = frag_len[j+1];
      end
      if (used > 0) used--;
    endfunction

    function logic [15:0] put_segment(logic [31:0] seq, logic [15:0] cnt,
                                      output logic [1:0] st);
      logic [31:0] seq_off, ns, nl, s, e;
      int i, stop, at;
      bit merged;
      merged = 0;
      st = ST_DONE;
      if (cnt == 0) return 0;
      if (seq_lo(head, seq) != head) begin
        st = ST_IGNORED;
        return 0;
      end
      seq_off = seq - head;
      if (longint'(seq_off) + longint'(cnt) > longint'(win)) begin
        st = ST_OVERFLOW;
        return 0;
      end
      // fold the segment into every fragment it meets
      ns = seq;
      nl = cnt;
      stop = used;
      i = 0;
      while (i < used) begin
        if (overlaps(ns, nl, frag_lo[i], frag_len[i])) begin
          s = seq_lo(ns, frag_lo[i]);
          e = seq_hi(ns + nl, frag_lo[i] + frag_len[i]);
          frag_lo[i] = s;
          frag_len[i] = 16'(e - s);
          if (merged) begin
            drop_frag(i - 1);
            i--;
          end
          ns = frag_lo[i];
          nl = frag_len[i];
          merged = 1;
        end else if (merged || seq_hi(seq + cnt, frag_lo[i]) == frag_lo[i]) begin
          stop = i;
          break;
        end
        i++;
      end
      // open a slot in order for a segment that met nothing
      if (!merged) begin
        if (used >= NFRAG) begin
          st = ST_FULL;
          return 0;
        end
        at = (used == 0 || seq_lo(seq, frag_lo[0]) == seq) ? 0 : stop;
        for (int j = used; j > at; j--) begin
          frag_lo[j] = frag_lo[j-1];
          frag_len[j] = frag_len[j-1];
        end
        frag_lo[at] = seq;
        frag_len[at] = cnt;
        used++;
      end
      if (used > 0 && frag_lo[0] == head) begin
        cumul = cumul + 32'(frag_len[0]) - contig;
        contig = frag_len[0];
      end
      return cnt;
    endfunction

    function logic [15:0] consume(logic [15:0] cnt);
      logic [31:0] n;
      n = cnt;
      if (contig < n) n = contig;
      if (n == 0 || used == 0) return 0;
      head += n;
      contig -= n;
      if (n >= frag_len[0]) drop_frag(0);
      else begin
        frag_lo[0] += n;
        frag_len[0] -= 16'(n);
      end
      return 16'(n);
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      if (idx == CFG_WINDOW) win = data[15:0];
      else if (idx == CFG_START) restart(data);
    endfunction

    function void note_item(logic op, logic [31:0] seq, logic [15:0] cnt);
      seg_result_t r;
      r.status = ST_DONE;
      if (op == OP_PUT) r.done_len = put_segment(seq, cnt, r.status);
      else r.done_len = consume(cnt);
      r.in_order_len = contig[15:0];
      r.head_sequence = head;
      r.total_in_order = cumul;
      r.fragment_count = 7'(used);
      pending_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(seg_result_t got);
      seg_result_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      w = pending_q.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.done_len !== w.done_len) report("done_len", got.done_len, w.done_len);
      if (got.in_order_len !== w.in_order_len)
        report("in_order_len", got.in_order_len, w.in_order_len);
      if (got.head_sequence !== w.head_sequence)
        report("head_sequence", got.head_sequence, w.head_sequence);
      if (got.total_in_order !== w.total_in_order)
        report("total_in_order", got.total_in_order, w.total_in_order);
      if (got.fragment_count !== w.fragment_count)
        report("fragment_count", got.fragment_count, w.fragment_count);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic opcode = OP_PUT;
  logic [31:0] seq_num = 0;
  logic [15:0] byte_count = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [15:0] done_len, in_order_len;
  logic [31:0] head_sequence, total_in_order;
  logic [6:0] fragment_count;
  logic cfg_we = 0;
  logic [7:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  reassembly_scoreboard sb;
  int send_idle_pct = 11;
  int recv_idle_pct = 57;
  int items_sent = 0;
  bit long_hold_req = 0;
  int quiet_cycles = 0;

  tcp_reassembly_interval_tracker_unit uut (.*);

  always #2 clk = ~clk;

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      out_ready = 0;
      repeat (400) @(negedge clk);
      long_hold_req = 0;
    end else
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({status, done_len, in_order_len, head_sequence, total_in_order,
                       fragment_count});
  end

  // watchdog on cycles with no traffic on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [31:0] seq, logic [15:0] cnt);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1;
    opcode = op;
    seq_num = seq;
    byte_count = cnt;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, seq, cnt);
    items_sent++;
    if (items_sent == 650) begin
      send_idle_pct = 57;
      recv_idle_pct = 11;
    end else if (items_sent == 1300) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // hold input until every expected result is back and the engine is quiet
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_items(int n);
    int r, off, len, lim;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (k == n / 2 && items_sent < 700) long_hold_req = 1;
      if (r < 60) begin
        // well-formed segment inside the window
        off = $urandom_range(0, sb.win > 1 ? sb.win - 1 : 0);
        lim = ($urandom_range(0, 7) == 0) ? sb.win : 40;
        if (off > 200 && $urandom_range(0, 1)) off = $urandom_range(0, 200);
        if (lim > sb.win - off) lim = sb.win - off;
        len = $urandom_range(1, lim < 1 ? 1 : lim);
        send_item(OP_PUT, sb.head + off, 16'(len));
      end else if (r < 85) begin
        send_item(OP_REMOVE, $urandom, 16'($urandom_range(0, sb.contig + 20)));
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom, 16'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed corners on the reset settings
    send_item(OP_PUT, 32'd0, 16'd0);
    send_item(OP_PUT, 32'hFFFF_FFF0, 16'd5);
    send_item(OP_PUT, 32'h8000_0000, 16'd1);
    send_item(OP_PUT, 32'd8000, 16'd193);
    send_item(OP_REMOVE, 32'd0, 16'd10);
    send_item(OP_PUT, 32'd10, 16'd10);
    send_item(OP_PUT, 32'd20, 16'd5);
    send_item(OP_PUT, 32'd26, 16'd4);
    send_item(OP_PUT, 32'd12, 16'd3);
    send_item(OP_PUT, 32'd0, 16'd10);
    send_item(OP_REMOVE, 32'd0, 16'd0);
    send_item(OP_REMOVE, 32'd0, 16'hFFFF);
    for (int k = 0; k < NFRAG + 1; k++)
      send_item(OP_PUT, sb.head + 100 + 4 * k, 16'd2);
    send_item(OP_PUT, sb.head + 99, 16'd70);
    drain();

    write_cfg(CFG_WINDOW, 32'd65535);
    write_cfg(CFG_START, 32'hFFFF_FF00);
    write_cfg(8'd5, 32'hFFFF_FFFF);
    send_item(OP_PUT, 32'hFFFF_FF00, 16'hFFFF);
    send_item(OP_REMOVE, 32'd0, 16'hFFFF);
    random_items(380);
    drain();

    write_cfg(CFG_WINDOW, 32'd1);
    write_cfg(CFG_START, 32'h7FFF_FFFF);
    random_items(380);
    drain();

    write_cfg(CFG_WINDOW, 32'd300);
    write_cfg(CFG_START, $urandom);
    random_items(380);
    drain();

    write_cfg(CFG_WINDOW, 32'd8192);
    write_cfg(CFG_START, 32'd0);
    random_items(380);
    drain();

    write_cfg(CFG_WINDOW, 32'd65535);
    write_cfg(CFG_START, $urandom);
    random_items(380);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
